@@ src/rtms_pkg.sv @@
// Shared types and constants for the resistive touch measure sequencer.
`timescale 1ns / 1ps
package rtms_pkg;

	localparam int ADC_BITS_DEF    = 12;
	localparam int SETTLE_BITS_DEF = 16;
	localparam int CFG_W           = 16;
	localparam int VALUE_W         = 12;
	localparam logic [CFG_W-1:0] SETTLE_RESET = 16'hFFFF;

	typedef enum logic [1:0] {
		PM_OFF     = 2'd0,
		PM_UP      = 2'd1,
		PM_DOWN    = 2'd2,
		PM_UP200K  = 2'd3
	} pin_mode_t;

	typedef enum logic [4:0] {
		PH_PRE1   = 5'd0,
		PH_I_PRE1 = 5'd1,
		PH_DET1   = 5'd2,
		PH_I_DET1 = 5'd3,
		PH_XSET   = 5'd4,
		PH_XTRIG  = 5'd5,
		PH_XWAIT  = 5'd6,
		PH_I_X    = 5'd7,
		PH_YSET   = 5'd8,
		PH_YTRIG  = 5'd9,
		PH_YWAIT  = 5'd10,
		PH_I_Y    = 5'd11,
		PH_PRE2   = 5'd12,
		PH_I_PRE2 = 5'd13,
		PH_DET2   = 5'd14,
		PH_I_DET2 = 5'd15
	} phase_t;

	typedef struct packed {
		logic               touch_detected;
		logic               conversion_done;
		logic [VALUE_W-1:0] conversion_value;
	} rtms_in_t;

	typedef struct packed {
		pin_mode_t          xpul_mode;
		pin_mode_t          xnur_mode;
		pin_mode_t          ypll_mode;
		pin_mode_t          ynlr_mode;
		pin_mode_t          wiper_mode;
		logic               detect_enable;
		logic               adc_trigger;
		logic               adc_channel;
		logic               adc_clear;
		logic               coord_valid;
		logic [VALUE_W-1:0] x_coord;
		logic [VALUE_W-1:0] y_coord;
	} rtms_result_t;

endpackage

@@ src/rtms_seq.sv @@
// Phase sequencer: settle counter, samples, pin drive and ADC control for one tick.
`timescale 1ns / 1ps
module rtms_seq #(
	parameter int ADC_BITS    = rtms_pkg::ADC_BITS_DEF,
	parameter int SETTLE_BITS = rtms_pkg::SETTLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [rtms_pkg::CFG_W-1:0]    cfg_wr_data,
	input  logic                          advance,
	input  rtms_pkg::rtms_in_t            item,
	output rtms_pkg::rtms_result_t        result
);
	import rtms_pkg::*;

	localparam int CW = ((SETTLE_BITS > CFG_W) ? SETTLE_BITS : CFG_W) + 1;
	localparam logic [CW-1:0] SETTLE_MAX = (CW'(1) << SETTLE_BITS) - CW'(1);
	localparam logic [VALUE_W-1:0] ADC_MASK =
		(ADC_BITS >= VALUE_W) ? {VALUE_W{1'b1}} : VALUE_W'((1 << ADC_BITS) - 1);

	logic [CFG_W-1:0]       settle_ticks_q;
	phase_t                 phase_q;
	phase_t                 phase_nxt;
	logic [SETTLE_BITS-1:0] cnt_q;
	logic [SETTLE_BITS-1:0] cnt_nxt;
	logic [VALUE_W-1:0]     x_q;
	logic [VALUE_W-1:0]     y_q;
	logic [VALUE_W-1:0]     value;
	logic [CW-1:0]          limit_raw;
	logic [CW-1:0]          limit;
	logic [CW-1:0]          cnt_inc;
	logic                   settle_hit;
	logic                   settle_phase;
	logic                   x_take;
	logic                   y_take;

	assign value = item.conversion_value & ADC_MASK;

	// zero counts as one tick; clamp to what the counter can reach
	always_comb begin
		limit_raw = CW'(settle_ticks_q);
		if (limit_raw == CW'(0)) begin
			limit_raw = CW'(1);
		end
		limit = (limit_raw > SETTLE_MAX) ? SETTLE_MAX : limit_raw;
	end

	assign cnt_inc    = CW'(cnt_q) + CW'(1);
	assign settle_hit = (cnt_inc >= limit);

	assign settle_phase = (phase_q == PH_PRE1) || (phase_q == PH_PRE2) ||
		(phase_q == PH_DET2) || (phase_q == PH_XSET) || (phase_q == PH_YSET);

	assign x_take = (phase_q == PH_XWAIT) && item.conversion_done;
	assign y_take = (phase_q == PH_YWAIT) && item.conversion_done;

	// next state
	always_comb begin
		phase_nxt = phase_q;
		unique case (phase_q)
			PH_PRE1:   if (settle_hit) phase_nxt = PH_I_PRE1;
			PH_I_PRE1: phase_nxt = PH_DET1;
			PH_DET1:   if (item.touch_detected) phase_nxt = PH_I_DET1;
			PH_I_DET1: phase_nxt = PH_XSET;
			PH_XSET:   if (settle_hit) phase_nxt = PH_XTRIG;
			PH_XTRIG:  phase_nxt = PH_XWAIT;
			PH_XWAIT:  if (item.conversion_done) phase_nxt = PH_I_X;
			PH_I_X:    phase_nxt = PH_YSET;
			PH_YSET:   if (settle_hit) phase_nxt = PH_YTRIG;
			PH_YTRIG:  phase_nxt = PH_YWAIT;
			PH_YWAIT:  if (item.conversion_done) phase_nxt = PH_I_Y;
			PH_I_Y:    phase_nxt = PH_PRE2;
			PH_PRE2:   if (settle_hit) phase_nxt = PH_I_PRE2;
			PH_I_PRE2: phase_nxt = PH_DET2;
			PH_DET2:   if (settle_hit) phase_nxt = PH_I_DET2;
			PH_I_DET2: phase_nxt = PH_PRE1;
			default:   phase_nxt = PH_PRE1;
		endcase
	end

	always_comb begin
		cnt_nxt = cnt_q;
		if (settle_phase) begin
			cnt_nxt = settle_hit ? '0 : cnt_q + SETTLE_BITS'(1);
		end else if (phase_q > PH_I_DET2) begin
			cnt_nxt = '0;
		end
	end

	// outputs
	always_comb begin
		result            = '0;
		result.xpul_mode  = PM_UP200K;
		result.xnur_mode  = PM_OFF;
		result.ypll_mode  = PM_OFF;
		result.ynlr_mode  = PM_OFF;
		result.wiper_mode = PM_OFF;
		result.x_coord    = x_take ? value : x_q;
		result.y_coord    = y_take ? value : y_q;
		unique case (phase_q)
			PH_PRE1, PH_PRE2: begin
				result.xnur_mode = PM_UP200K;
			end
			PH_DET1: begin
				result.ypll_mode     = PM_DOWN;
				result.ynlr_mode     = PM_DOWN;
				result.detect_enable = 1'b1;
			end
			PH_DET2: begin
				result.ypll_mode     = PM_DOWN;
				result.ynlr_mode     = PM_DOWN;
				result.detect_enable = 1'b1;
				result.coord_valid   = settle_hit && item.touch_detected;
			end
			PH_XSET, PH_XTRIG, PH_XWAIT: begin
				result.xpul_mode   = PM_UP;
				result.xnur_mode   = PM_DOWN;
				result.adc_trigger = (phase_q == PH_XTRIG);
				result.adc_channel = (phase_q == PH_XTRIG);
				result.adc_clear   = x_take;
			end
			PH_YSET, PH_YTRIG, PH_YWAIT: begin
				result.xpul_mode   = PM_OFF;
				result.ypll_mode   = PM_UP;
				result.ynlr_mode   = PM_DOWN;
				result.adc_trigger = (phase_q == PH_YTRIG);
				result.adc_clear   = y_take;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_ticks_q <= SETTLE_RESET;
		end else if (cfg_wr_en) begin
			settle_ticks_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PRE1;
			cnt_q   <= '0;
			x_q     <= '0;
			y_q     <= '0;
		end else if (advance) begin
			phase_q <= phase_nxt;
			cnt_q   <= cnt_nxt;
			if (x_take) begin
				x_q <= value;
			end
			if (y_take) begin
				y_q <= value;
			end
		end
	end

endmodule

@@ src/resistive_touch_measure_sequencer_core.sv @@
// Top level: request input register, phase sequencer and result register.
// A request accepted into the input register steps the phase sequencer once
// the result register is free, and its result is then held in the result register.
// Throughput: one request per cycle while the result side does not stall; the
// result register and the input register each hold one request, so a stall on the
// result side backs up through both before the input side stalls.
// Reset (arst_n low): first precharge phase, counter and samples cleared,
// settle length 0xFFFF, both registers empty.
`timescale 1ns / 1ps
module resistive_touch_measure_sequencer_core #(
	parameter int ADC_BITS    = rtms_pkg::ADC_BITS_DEF,
	parameter int SETTLE_BITS = rtms_pkg::SETTLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [rtms_pkg::CFG_W-1:0]    cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          touch_detected,
	input  logic                          conversion_done,
	input  logic [rtms_pkg::VALUE_W-1:0]  conversion_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    xpul_mode,
	output logic [1:0]                    xnur_mode,
	output logic [1:0]                    ypll_mode,
	output logic [1:0]                    ynlr_mode,
	output logic [1:0]                    wiper_mode,
	output logic                          detect_enable,
	output logic                          adc_trigger,
	output logic                          adc_channel,
	output logic                          adc_clear,
	output logic                          coord_valid,
	output logic [rtms_pkg::VALUE_W-1:0]  x_coord,
	output logic [rtms_pkg::VALUE_W-1:0]  y_coord
);
	import rtms_pkg::*;

	logic         req_valid_s1;
	rtms_in_t     req_s1;
	logic         res_valid_s2;
	rtms_result_t res_s2;
	rtms_result_t res_comb;
	logic         out_free;
	logic         advance;
	logic         accept;

	assign out_free = !res_valid_s2 || !out_stall;
	assign advance  = req_valid_s1 && out_free;
	assign in_stall = req_valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (accept) begin
			req_valid_s1 <= 1'b1;
		end else if (advance) begin
			req_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.touch_detected   <= touch_detected;
			req_s1.conversion_done  <= conversion_done;
			req_s1.conversion_value <= conversion_value;
		end
	end

	rtms_seq #(
		.ADC_BITS    (ADC_BITS),
		.SETTLE_BITS (SETTLE_BITS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.advance     (advance),
		.item        (req_s1),
		.result      (res_comb)
	);

	// hold the result while stalled, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid     = res_valid_s2;
	assign xpul_mode     = res_s2.xpul_mode;
	assign xnur_mode     = res_s2.xnur_mode;
	assign ypll_mode     = res_s2.ypll_mode;
	assign ynlr_mode     = res_s2.ynlr_mode;
	assign wiper_mode    = res_s2.wiper_mode;
	assign detect_enable = res_s2.detect_enable;
	assign adc_trigger   = res_s2.adc_trigger;
	assign adc_channel   = res_s2.adc_channel;
	assign adc_clear     = res_s2.adc_clear;
	assign coord_valid   = res_s2.coord_valid;
	assign x_coord       = res_s2.x_coord;
	assign y_coord       = res_s2.y_coord;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the touch measure sequencer: directed and randomized ticks, predicted drives.
`timescale 1ns / 1ps
module tb;
	import rtms_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [CFG_W-1:0]    cfg_wr_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                touch_detected = 1'b0;
	logic                conversion_done = 1'b0;
	logic [VALUE_W-1:0]  conversion_value = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [1:0]          xpul_mode;
	logic [1:0]          xnur_mode;
	logic [1:0]          ypll_mode;
	logic [1:0]          ynlr_mode;
	logic [1:0]          wiper_mode;
	logic                detect_enable;
	logic                adc_trigger;
	logic                adc_channel;
	logic                adc_clear;
	logic                coord_valid;
	logic [VALUE_W-1:0]  x_coord;
	logic [VALUE_W-1:0]  y_coord;

	// sequencer shadow state
	phase_t              cur_phase = PH_PRE1;
	logic [CFG_W-1:0]    settle_len = SETTLE_RESET;
	logic [CFG_W-1:0]    settle_cnt = '0;
	logic [VALUE_W-1:0]  x_held = '0;
	logic [VALUE_W-1:0]  y_held = '0;

	rtms_in_t            tick_q[$];
	rtms_result_t        drive_q[$];
	rtms_in_t            cur_tick;
	rtms_result_t        got;
	rtms_result_t        want;
	int unsigned         err_cnt = 0;
	int unsigned         cycle_cnt = 0;
	int unsigned         gap_left = 0;
	int unsigned         burst_left = 0;
	int unsigned         stall_left = 0;
	int unsigned         stall_mode = 0;

	resistive_touch_measure_sequencer_core u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.touch_detected   (touch_detected),
		.conversion_done  (conversion_done),
		.conversion_value (conversion_value),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.xpul_mode        (xpul_mode),
		.xnur_mode        (xnur_mode),
		.ypll_mode        (ypll_mode),
		.ynlr_mode        (ynlr_mode),
		.wiper_mode       (wiper_mode),
		.detect_enable    (detect_enable),
		.adc_trigger      (adc_trigger),
		.adc_channel      (adc_channel),
		.adc_clear        (adc_clear),
		.coord_valid      (coord_valid),
		.x_coord          (x_coord),
		.y_coord          (y_coord)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Count one settle tick; true on the last tick of the settle window.
	function automatic bit settle_expired();
		logic [CFG_W:0] lim;
		lim = (settle_len == '0) ? 17'd1 : {1'b0, settle_len};
		if ({1'b0, settle_cnt} + 17'd1 >= lim) begin
			settle_cnt = '0;
			return 1'b1;
		end
		settle_cnt = settle_cnt + 1'b1;
		return 1'b0;
	endfunction

	function automatic void set_pins(inout rtms_result_t r, input pin_mode_t xp,
			input pin_mode_t xn, input pin_mode_t yp, input pin_mode_t yn);
		r.xpul_mode = xp;
		r.xnur_mode = xn;
		r.ypll_mode = yp;
		r.ynlr_mode = yn;
	endfunction

	function automatic rtms_result_t sequence_tick(input rtms_in_t t);
		rtms_result_t r;
		phase_t       nxt;
		r = '0;
		nxt = cur_phase;
		set_pins(r, PM_UP200K, PM_OFF, PM_OFF, PM_OFF);
		r.wiper_mode = PM_OFF;
		case (cur_phase)
			PH_PRE1, PH_PRE2: begin
				set_pins(r, PM_UP200K, PM_UP200K, PM_OFF, PM_OFF);
				if (settle_expired())
					nxt = phase_t'(cur_phase + 1);
			end
			PH_DET1: begin
				set_pins(r, PM_UP200K, PM_OFF, PM_DOWN, PM_DOWN);
				r.detect_enable = 1'b1;
				if (t.touch_detected)
					nxt = PH_I_DET1;
			end
			PH_DET2: begin
				set_pins(r, PM_UP200K, PM_OFF, PM_DOWN, PM_DOWN);
				r.detect_enable = 1'b1;
				if (settle_expired()) begin
					r.coord_valid = t.touch_detected;
					nxt = PH_I_DET2;
				end
			end
			PH_XSET: begin
				set_pins(r, PM_UP, PM_DOWN, PM_OFF, PM_OFF);
				if (settle_expired())
					nxt = PH_XTRIG;
			end
			PH_XTRIG: begin
				set_pins(r, PM_UP, PM_DOWN, PM_OFF, PM_OFF);
				r.adc_trigger = 1'b1;
				r.adc_channel = 1'b1;
				nxt = PH_XWAIT;
			end
			PH_XWAIT: begin
				set_pins(r, PM_UP, PM_DOWN, PM_OFF, PM_OFF);
				if (t.conversion_done) begin
					r.adc_clear = 1'b1;
					x_held = t.conversion_value;
					nxt = PH_I_X;
				end
			end
			PH_YSET: begin
				set_pins(r, PM_OFF, PM_OFF, PM_UP, PM_DOWN);
				if (settle_expired())
					nxt = PH_YTRIG;
			end
			PH_YTRIG: begin
				set_pins(r, PM_OFF, PM_OFF, PM_UP, PM_DOWN);
				r.adc_trigger = 1'b1;
				nxt = PH_YWAIT;
			end
			PH_YWAIT: begin
				set_pins(r, PM_OFF, PM_OFF, PM_UP, PM_DOWN);
				if (t.conversion_done) begin
					r.adc_clear = 1'b1;
					y_held = t.conversion_value;
					nxt = PH_I_Y;
				end
			end
			PH_I_PRE1, PH_I_DET1, PH_I_X, PH_I_Y, PH_I_PRE2: begin
				nxt = phase_t'(cur_phase + 1);
			end
			default: begin
				// last intermediate tick wraps to the first precharge
				nxt = PH_PRE1;
				settle_cnt = '0;
			end
		endcase
		r.x_coord = x_held;
		r.y_coord = y_held;
		cur_phase = nxt;
		return r;
	endfunction

	task automatic add_tick(input bit touch, input bit done, input logic [VALUE_W-1:0] value);
		rtms_in_t t;
		t.touch_detected = touch;
		t.conversion_done = done;
		t.conversion_value = value;
		tick_q.push_back(t);
	endtask

	task automatic add_random_ticks(input int n, input int touch_pct, input int done_pct);
		for (int i = 0; i < n; i++)
			add_tick($urandom_range(0, 99) < touch_pct, $urandom_range(0, 99) < done_pct,
				$urandom_range(0, 4095));
	endtask

	// Check at the falling edge so that all edge updates have landed.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (tick_q.size() != 0 || in_valid || drive_q.size() != 0);
	endtask

	task automatic set_settle(input logic [CFG_W-1:0] v);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_wr_data <= v;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic compare_field(input string name, input logic [VALUE_W-1:0] want_v,
			input logic [VALUE_W-1:0] got_v);
		if (got_v !== want_v) begin
			err_cnt++;
			if (err_cnt <= 10)
				$display("mismatch on %s: expected %0h, got %0h", name, want_v, got_v);
		end
	endtask

	// Sender: track the shadow sequencer, then launch the next request in bursts.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en)
				settle_len = cfg_wr_data;
			if (in_valid && !in_stall)
				drive_q.push_back(sequence_tick(cur_tick));
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (tick_q.size() != 0) begin
					cur_tick = tick_q.pop_front();
					touch_detected <= cur_tick.touch_detected;
					conversion_done <= cur_tick.conversion_done;
					conversion_value <= cur_tick.conversion_value;
					in_valid <= 1'b1;
					if (burst_left != 0) begin
						burst_left--;
					end else if ($urandom_range(0, 7) == 0) begin
						burst_left = $urandom_range(100, 300);
						gap_left = 0;
					end else begin
						burst_left = $urandom_range(0, 23);
						gap_left = $urandom_range(1, 6);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: pick a new random stall behavior whenever the current one runs out.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(32, 200);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 9) < 7);
			default: out_stall <= (stall_left % 5 != 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got.xpul_mode = pin_mode_t'(xpul_mode);
			got.xnur_mode = pin_mode_t'(xnur_mode);
			got.ypll_mode = pin_mode_t'(ypll_mode);
			got.ynlr_mode = pin_mode_t'(ynlr_mode);
			got.wiper_mode = pin_mode_t'(wiper_mode);
			got.detect_enable = detect_enable;
			got.adc_trigger = adc_trigger;
			got.adc_channel = adc_channel;
			got.adc_clear = adc_clear;
			got.coord_valid = coord_valid;
			got.x_coord = x_coord;
			got.y_coord = y_coord;
			if (drive_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("result with nothing expected: %p", got);
			end else begin
				want = drive_q.pop_front();
				compare_field("xpul_mode", want.xpul_mode, got.xpul_mode);
				compare_field("xnur_mode", want.xnur_mode, got.xnur_mode);
				compare_field("ypll_mode", want.ypll_mode, got.ypll_mode);
				compare_field("ynlr_mode", want.ynlr_mode, got.ynlr_mode);
				compare_field("wiper_mode", want.wiper_mode, got.wiper_mode);
				compare_field("detect_enable", want.detect_enable, got.detect_enable);
				compare_field("adc_trigger", want.adc_trigger, got.adc_trigger);
				compare_field("adc_channel", want.adc_channel, got.adc_channel);
				compare_field("adc_clear", want.adc_clear, got.adc_clear);
				compare_field("coord_valid", want.coord_valid, got.coord_valid);
				compare_field("x_coord", want.x_coord, got.x_coord);
				compare_field("y_coord", want.y_coord, got.y_coord);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// a few ticks at the reset settle length, still inside the first precharge
		add_random_ticks(6, 50, 50);

		// zero length acts as one tick per settle phase; walk one full sequence
		set_settle(16'd0);
		add_tick(1'b0, 1'b0, 12'h000);  // first precharge ends at once
		add_tick(1'b1, 1'b1, 12'hfff);
		add_tick(1'b0, 1'b0, 12'h000);  // detect: hold while untouched
		add_tick(1'b0, 1'b1, 12'hfff);
		add_tick(1'b1, 1'b0, 12'h123);
		add_tick(1'b0, 1'b0, 12'h000);
		add_tick(1'b0, 1'b0, 12'h000);
		add_tick(1'b1, 1'b1, 12'h555);  // done on the trigger tick is dropped
		add_tick(1'b0, 1'b0, 12'hfff);
		add_tick(1'b0, 1'b1, 12'hfff);  // X captured at full scale
		add_tick(1'b0, 1'b0, 12'h000);
		add_tick(1'b0, 1'b0, 12'h000);
		add_tick(1'b0, 1'b1, 12'haaa);
		add_tick(1'b1, 1'b1, 12'h000);  // Y captured at zero
		add_tick(1'b0, 1'b0, 12'h000);
		add_tick(1'b0, 1'b0, 12'h000);
		add_tick(1'b0, 1'b0, 12'h000);
		add_tick(1'b1, 1'b0, 12'h000);  // second detect confirms the touch
		add_tick(1'b0, 1'b0, 12'h000);
		add_random_ticks(300, 35, 30);

		set_settle(16'd1);
		add_random_ticks(200, 10, 10);
		set_settle(16'd2);
		add_random_ticks(250, 50, 50);
		set_settle(16'd5);
		add_random_ticks(200, 25, 20);
		set_settle(16'hffff);
		add_random_ticks(80, 50, 50);
		// leftover count may already exceed the shorter window
		set_settle(16'd17);
		add_random_ticks(150, 40, 30);
		for (int i = 0; i < 4; i++) begin
			set_settle(16'($urandom_range(1, 8)));
			add_random_ticks(65, 35, 25);
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (err_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ resistive_touch_measure_sequencer_core.f @@
src/rtms_pkg.sv
src/rtms_seq.sv
src/resistive_touch_measure_sequencer_core.sv
tb/tb.sv
